// File: sv/lpwd_pkg.sv
// shared types and constants for the length-prefixed word deframer
`timescale 1ns / 1ps

package lpwd_pkg;

	// fixed field widths
	localparam int BYTE_W       = 8;
	localparam int LEN_W        = 28;
	localparam int ACC_W        = 28;
	localparam int DEF_LEN_BITS = 28;

	// prefix classification: first byte masks and match values
	localparam logic [BYTE_W-1:0] PFX2_MASK  = 8'hc0;
	localparam logic [BYTE_W-1:0] PFX2_MATCH = 8'h80;
	localparam logic [BYTE_W-1:0] PFX3_MASK  = 8'he0;
	localparam logic [BYTE_W-1:0] PFX3_MATCH = 8'hc0;

	// length bits kept from the first byte of each prefix form
	localparam logic [BYTE_W-1:0] LEN1_MASK = 8'h7f;
	localparam logic [BYTE_W-1:0] LEN2_MASK = 8'h3f;
	localparam logic [BYTE_W-1:0] LEN3_MASK = 8'h1f;
	localparam logic [BYTE_W-1:0] LEN4_MASK = 8'h0f;

	// number of prefix bytes that follow the first one
	localparam logic [1:0] MORE_PFX2 = 2'd1;
	localparam logic [1:0] MORE_PFX3 = 2'd2;
	localparam logic [1:0] MORE_PFX4 = 2'd3;

	typedef enum logic [1:0] {
		PH_PREFIX0 = 2'd0,
		PH_PREFIXN = 2'd1,
		PH_PAYLOAD = 2'd2
	} lpwd_phase_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_EOS     = 1'b1
	} lpwd_kind_t;

	typedef struct packed {
		lpwd_kind_t        kind;
		logic [BYTE_W-1:0] payload;
		logic              first_of_word;
		logic              last_of_word;
		logic [LEN_W-1:0]  word_length;
	} lpwd_word_t;

endpackage

// File: sv/lpwd_if.sv
// valid/ready channel interfaces for received bytes and deframed words
`timescale 1ns / 1ps

interface lpwd_byte_if;
	logic                        valid;
	logic                        ready;
	logic [lpwd_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpwd_word_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [lpwd_pkg::BYTE_W-1:0] payload;
	logic                        first_of_word;
	logic                        last_of_word;
	logic [lpwd_pkg::LEN_W-1:0]  word_length;

	modport source (output valid, output kind, output payload, output first_of_word,
		output last_of_word, output word_length, input ready);
	modport sink   (input valid, input kind, input payload, input first_of_word,
		input last_of_word, input word_length, output ready);
endinterface

// File: sv/lpwd_decoder.sv
// prefix decoding state machine and per-byte result generation
`timescale 1ns / 1ps

module lpwd_decoder #(
	parameter int LEN_BITS = lpwd_pkg::DEF_LEN_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [lpwd_pkg::BYTE_W-1:0] data_byte,
	output logic                        res_valid,
	output lpwd_pkg::lpwd_word_t        res
);

	lpwd_pkg::lpwd_phase_t       phase_q, phase_d;
	logic [1:0]                  prefix_left_q, prefix_left_d;
	logic [lpwd_pkg::ACC_W-1:0]  length_acc_q, length_acc_d;
	logic [LEN_BITS-1:0]         payload_left_q, payload_left_d;
	logic [LEN_BITS-1:0]         held_length_q, held_length_d;
	logic                        at_word_start_q, at_word_start_d;

	logic                        len_done;
	logic [LEN_BITS-1:0]         done_len;
	logic                        last;

	// state registers, updated on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= lpwd_pkg::PH_PREFIX0;
			prefix_left_q   <= '0;
			length_acc_q    <= '0;
			payload_left_q  <= '0;
			held_length_q   <= '0;
			at_word_start_q <= 1'b1;
		end else if (accept) begin
			phase_q         <= phase_d;
			prefix_left_q   <= prefix_left_d;
			length_acc_q    <= length_acc_d;
			payload_left_q  <= payload_left_d;
			held_length_q   <= held_length_d;
			at_word_start_q <= at_word_start_d;
		end
	end

	// next state and result for the byte on the input
	always_comb begin
		phase_d         = phase_q;
		prefix_left_d   = prefix_left_q;
		length_acc_d    = length_acc_q;
		payload_left_d  = payload_left_q;
		held_length_d   = held_length_q;
		at_word_start_d = at_word_start_q;
		len_done        = 1'b0;
		done_len        = '0;
		last            = 1'b0;
		res_valid       = 1'b0;
		res             = '0;

		case (phase_q)
			lpwd_pkg::PH_PAYLOAD: begin
				last              = (payload_left_q <= LEN_BITS'(1));
				res_valid         = 1'b1;
				res.kind          = lpwd_pkg::KIND_PAYLOAD;
				res.payload       = data_byte;
				res.first_of_word = at_word_start_q;
				res.last_of_word  = last;
				res.word_length   = lpwd_pkg::LEN_W'(held_length_q);
				at_word_start_d   = 1'b0;
				if (last) begin
					payload_left_d  = '0;
					phase_d         = lpwd_pkg::PH_PREFIX0;
					at_word_start_d = 1'b1;
				end else begin
					payload_left_d = payload_left_q - LEN_BITS'(1);
				end
			end
			lpwd_pkg::PH_PREFIXN: begin
				length_acc_d  = {length_acc_q[lpwd_pkg::ACC_W-lpwd_pkg::BYTE_W-1:0], data_byte};
				prefix_left_d = prefix_left_q - 2'd1;
				if (prefix_left_d == 2'd0) begin
					len_done = 1'b1;
					done_len = length_acc_d[LEN_BITS-1:0];
				end
			end
			default: begin
				// first prefix byte; its top bits select the prefix form
				if (!data_byte[lpwd_pkg::BYTE_W-1]) begin
					len_done = 1'b1;
					done_len = LEN_BITS'(data_byte & lpwd_pkg::LEN1_MASK);
				end else begin
					phase_d = lpwd_pkg::PH_PREFIXN;
					if ((data_byte & lpwd_pkg::PFX2_MASK) == lpwd_pkg::PFX2_MATCH) begin
						length_acc_d  = lpwd_pkg::ACC_W'(data_byte & lpwd_pkg::LEN2_MASK);
						prefix_left_d = lpwd_pkg::MORE_PFX2;
					end else if ((data_byte & lpwd_pkg::PFX3_MASK) == lpwd_pkg::PFX3_MATCH) begin
						length_acc_d  = lpwd_pkg::ACC_W'(data_byte & lpwd_pkg::LEN3_MASK);
						prefix_left_d = lpwd_pkg::MORE_PFX3;
					end else begin
						length_acc_d  = lpwd_pkg::ACC_W'(data_byte & lpwd_pkg::LEN4_MASK);
						prefix_left_d = lpwd_pkg::MORE_PFX4;
					end
				end
			end
		endcase

		// complete length: zero ends the sentence, otherwise start the payload
		if (len_done) begin
			prefix_left_d   = '0;
			at_word_start_d = 1'b1;
			if (done_len == '0) begin
				phase_d   = lpwd_pkg::PH_PREFIX0;
				res_valid = 1'b1;
				res.kind  = lpwd_pkg::KIND_EOS;
			end else begin
				held_length_d  = done_len;
				payload_left_d = done_len;
				phase_d        = lpwd_pkg::PH_PAYLOAD;
			end
		end
	end

endmodule

// File: sv/length_prefixed_word_deframer.sv
// length-prefixed word deframer: byte stream in, payload bytes and sentence ends out
// an accepted byte's result is registered in the output register
// throughput: one byte per cycle unless a waiting result is not drained; the decoder state updates per accepted byte
// a new byte is taken while a result waits, as long as the output is drained that cycle
// prefix bytes give no result; a zero-length word gives one sentence-end result
// reset: asynchronous, active low; expects a first prefix byte and clears the output
`timescale 1ns / 1ps

module length_prefixed_word_deframer #(
	parameter int LEN_BITS = lpwd_pkg::DEF_LEN_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	lpwd_byte_if.sink   bytes,
	lpwd_word_if.source words
);

	logic                 accept;
	logic                 res_valid;
	lpwd_pkg::lpwd_word_t res;
	logic                 out_valid_q;
	lpwd_pkg::lpwd_word_t out_item_q;

	// take a request when the output register is free or being drained
	assign bytes.ready = !out_valid_q || words.ready;
	assign accept      = bytes.valid && bytes.ready;

	lpwd_decoder #(
		.LEN_BITS (LEN_BITS)
	) u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (bytes.data_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (words.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word register: kind, payload, word flags and length
	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_item_q <= res;
		end
	end

	assign words.valid         = out_valid_q;
	assign words.kind          = out_item_q.kind;
	assign words.payload       = out_item_q.payload;
	assign words.first_of_word = out_item_q.first_of_word;
	assign words.last_of_word  = out_item_q.last_of_word;
	assign words.word_length   = out_item_q.word_length;

endmodule

// File: dv/tb_top.sv
// testbench for the length-prefixed word deframer: byte stream in, checked words out
`timescale 1ns / 1ps

module tb_top;
	import lpwd_pkg::*;

	localparam int          LEN_BITS   = DEF_LEN_BITS;
	localparam int          NUM_BYTES  = 1000;
	localparam int          IDLE_LIMIT = 2000;
	localparam int          HOLD_AT    = 400;
	localparam int          HOLD_LEN   = 200;

	// expected word stream, worked out from every accepted byte
	class word_scoreboard;
		lpwd_phase_t      phase;
		logic [1:0]       prefix_left;
		logic [ACC_W-1:0] length_acc;
		logic [ACC_W-1:0] payload_left;
		logic [LEN_W-1:0] held_length;
		logic             at_word_start;
		lpwd_word_t       expected_words[$];
		int               errors;

		function new();
			phase         = PH_PREFIX0;
			prefix_left   = '0;
			length_acc    = '0;
			payload_left  = '0;
			held_length   = '0;
			at_word_start = 1'b1;
			errors        = 0;
		endfunction

		// a complete length either opens a payload or ends the sentence
		function void close_length(input logic [ACC_W-1:0] len_in);
			logic [31:0]      keep_mask;
			logic [ACC_W-1:0] len;
			lpwd_word_t       w;
			keep_mask   = (32'd1 << LEN_BITS) - 32'd1;
			len         = len_in & keep_mask[ACC_W-1:0];
			prefix_left = '0;
			at_word_start = 1'b1;
			if (len == '0) begin
				phase           = PH_PREFIX0;
				w.kind          = KIND_EOS;
				w.payload       = '0;
				w.first_of_word = 1'b0;
				w.last_of_word  = 1'b0;
				w.word_length   = '0;
				expected_words.push_back(w);
			end else begin
				held_length  = len;
				payload_left = len;
				phase        = PH_PAYLOAD;
			end
		endfunction

		// step the deframer state by one accepted byte
		function void note_byte(input logic [BYTE_W-1:0] b);
			lpwd_word_t w;
			logic       last;
			if (phase == PH_PAYLOAD) begin
				last            = (payload_left <= 1);
				w.kind          = KIND_PAYLOAD;
				w.payload       = b;
				w.first_of_word = at_word_start;
				w.last_of_word  = last;
				w.word_length   = held_length;
				expected_words.push_back(w);
				at_word_start = 1'b0;
				if (last) begin
					payload_left  = '0;
					phase         = PH_PREFIX0;
					at_word_start = 1'b1;
				end else begin
					payload_left = payload_left - 1;
				end
			end else if (phase == PH_PREFIXN) begin
				length_acc  = {length_acc[ACC_W-9:0], b};
				prefix_left = prefix_left - 2'd1;
				if (prefix_left == '0)
					close_length(length_acc);
			end else if (!b[7]) begin
				close_length(ACC_W'(b & LEN1_MASK));
			end else begin
				if ((b & PFX2_MASK) == PFX2_MATCH) begin
					length_acc  = ACC_W'(b & LEN2_MASK);
					prefix_left = MORE_PFX2;
				end else if ((b & PFX3_MASK) == PFX3_MATCH) begin
					length_acc  = ACC_W'(b & LEN3_MASK);
					prefix_left = MORE_PFX3;
				end else begin
					length_acc  = ACC_W'(b & LEN4_MASK);
					prefix_left = MORE_PFX4;
				end
				phase = PH_PREFIXN;
			end
		endfunction

		function void check_field(input string name, input logic [LEN_W-1:0] exp_v,
			input logic [LEN_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// compare one delivered word with the oldest expectation
		function void check_word(input lpwd_word_t got);
			lpwd_word_t exp_w;
			if (expected_words.size() == 0) begin
				$error("unexpected result: kind %0d payload 0x%0h", got.kind, got.payload);
				errors++;
			end else begin
				exp_w = expected_words.pop_front();
				check_field("kind", LEN_W'(exp_w.kind), LEN_W'(got.kind));
				check_field("payload", LEN_W'(exp_w.payload), LEN_W'(got.payload));
				check_field("first_of_word", LEN_W'(exp_w.first_of_word),
					LEN_W'(got.first_of_word));
				check_field("last_of_word", LEN_W'(exp_w.last_of_word),
					LEN_W'(got.last_of_word));
				check_field("word_length", exp_w.word_length, got.word_length);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lpwd_byte_if byte_ch ();
	lpwd_word_if word_ch ();

	length_prefixed_word_deframer #(
		.LEN_BITS(LEN_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (byte_ch),
		.words (word_ch)
	);

	word_scoreboard sb = new();
	int unsigned    bytes_sent = 0;
	int unsigned    burst_left = 0;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// offer one byte, with a random gap between bursts, and wait for the request to go through
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		sb.note_byte(b);
		bytes_sent++;
		burst_left--;
	endtask

	// encode a length with the given number of prefix bytes, then random payload bytes
	task automatic send_word(input int unsigned len, input int unsigned pfx_bytes);
		logic [LEN_W-1:0] l;
		int unsigned      i;
		l = LEN_W'(len);
		case (pfx_bytes)
			1: begin
				send_byte({1'b0, l[6:0]});
			end
			2: begin
				send_byte({2'b10, l[13:8]});
				send_byte(l[7:0]);
			end
			3: begin
				send_byte({3'b110, l[20:16]});
				send_byte(l[15:8]);
				send_byte(l[7:0]);
			end
			default: begin
				send_byte({3'b111, 1'($urandom_range(0, 1)), l[27:24]});
				send_byte(l[23:16]);
				send_byte(l[15:8]);
				send_byte(l[7:0]);
			end
		endcase
		for (i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// result side: check accepted words, stall on a changing pattern, one long hold-off
	initial begin
		lpwd_word_t  got;
		int unsigned stall_mode;
		int unsigned mode_left;
		int unsigned hold_left;
		bit          hold_done;
		stall_mode = 0;
		mode_left  = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		word_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (word_ch.valid && word_ch.ready) begin
				got.kind          = lpwd_kind_t'(word_ch.kind);
				got.payload       = word_ch.payload;
				got.first_of_word = word_ch.first_of_word;
				got.last_of_word  = word_ch.last_of_word;
				got.word_length   = word_ch.word_length;
				sb.check_word(got);
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(32, 256);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				word_ch.ready <= 1'b0;
			end else if (!hold_done && bytes_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				word_ch.ready <= 1'b0;
			end else if (stall_mode == 0) begin
				word_ch.ready <= 1'b1;
			end else if (stall_mode == 1) begin
				word_ch.ready <= 1'($urandom_range(0, 1));
			end else begin
				word_ch.ready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (word_ch.valid && word_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$error("no progress for %0d cycles", IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus and end of run
	initial begin
		logic [BYTE_W-1:0] directed_bytes[] = '{
			8'h00,                                  // sentence end, one-byte prefix
			8'h01, 8'ha5,                           // single-byte word
			8'h80, 8'h00,                           // sentence end, two-byte prefix
			8'hc0, 8'h00, 8'h02, 8'hff, 8'h00,      // three-byte prefix, two bytes
			8'hf0, 8'h00, 8'h00, 8'h01, 8'h5a,      // four-byte prefix with bit 4 set
			8'he0, 8'h00, 8'h00, 8'h00,             // sentence end, four-byte prefix
			8'h03, 8'h00, 8'h7f, 8'h80              // one-byte prefix, three bytes
		};
		int unsigned r;
		int unsigned len;
		int unsigned min_pfx;
		int unsigned pfx;
		int unsigned i;

		arst_n            <= 1'b0;
		byte_ch.valid     <= 1'b0;
		byte_ch.data_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed words
		foreach (directed_bytes[k])
			send_byte(directed_bytes[k]);

		// random words: mostly short, some sentence ends, a few long ones
		while (bytes_sent < NUM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				len = 0;
			else if (r < 80)
				len = $urandom_range(1, 8);
			else if (r < 98)
				len = $urandom_range(9, 127);
			else
				len = $urandom_range(128, 600);
			min_pfx = (len < 128) ? 1 : (len < 16384) ? 2 : 3;
			pfx = ($urandom_range(0, 1) == 0) ? min_pfx : $urandom_range(min_pfx, 4);
			send_word(len, pfx);
		end

		// largest length: open the word and send only a few of its bytes
		for (i = 0; i < 4; i++)
			send_byte(8'hff);
		for (i = 0; i < 6; i++)
			send_byte(8'($urandom_range(0, 255)));
		byte_ch.valid <= 1'b0;

		// drain, then wait a little longer for anything stray
		while (sb.expected_words.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (sb.expected_words.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_words.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
